// ----- rtl/core/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, types and the default key table for the RC4 core.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  // Permutation table geometry
  localparam int PERM_SIZE = 256;
  localparam int PERM_AW   = 8;

  // Key store limit default and fallback key
  localparam int MAX_KEY_BYTES_DEF = 255;
  localparam int DEFAULT_KEY_LEN   = 6;

  // Operation codes carried by the operation field
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Write request into the permutation memory
  typedef struct packed {
    logic               we;
    logic [PERM_AW-1:0] waddr;
    logic [7:0]         wdata;
  } perm_wr_t;

  // Fallback key "123456", used when no key bytes are stored
  function automatic logic [7:0] default_key_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h31;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h33;
      3'd3:    b = 8'h34;
      3'd4:    b = 8'h35;
      3'd5:    b = 8'h36;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rc4_perm_ram.sv -----
// ----------------------------------------------------------------------------
// rc4_perm_ram
// 256 x 8 permutation memory, one write and one registered read per cycle,
// read-first. Per-entry valid bits make an unwritten entry read as its own
// address, so reset and clear give the identity permutation at once.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_perm_ram
  import rc4_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               clear,
  input  wire perm_wr_t           wr,
  input  wire logic [PERM_AW-1:0] raddr,
  output logic      [7:0]         rdata
);

  logic [7:0]         mem [PERM_SIZE];
  logic [PERM_SIZE-1:0] vld;
  logic [7:0]         data_q;
  logic               vld_q;
  logic [PERM_AW-1:0] addr_q;

  // Storage and registered read (old data on same-address write)
  always_ff @(posedge clk) begin
    data_q <= mem[raddr];
    addr_q <= raddr;
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
  end

  // Valid bits: cleared by reset or by a new key schedule
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld[raddr];
      if (wr.we) begin
        vld[wr.waddr] <= 1'b1;
      end
    end
  end

  // Unwritten entries read as identity
  assign rdata = vld_q ? data_q : addr_q;

endmodule

`default_nettype wire

// ----- rtl/core/rc4_key_ram.sv -----
// ----------------------------------------------------------------------------
// rc4_key_ram
// Key byte store, one write and one registered read per cycle.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_key_ram #(
  parameter int DEPTH = 255,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rc4_stream_cipher.sv -----
// Key beat: accepted while idle and written to the key store on acceptance, no result.
// Data beat: read / swap / read through the one read port of the perm memory in ST_ST_B,
//   ST_ST_C and ST_ST_D; result registered in ST_ST_D, no new beat until it is loaded.
// Data beat flagged first: the key schedule (ST_KS_RD, ST_KS_B, ST_KS_C) runs before it.
// Reset clears control state and the permutation valid bits (identity table at once);
// no clearing pass. The key store holds no reset value.
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte cipher: key bytes go to a key store, data bytes are XORed with
// the keystream, a first data beat reruns the key schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       operation,
  input  wire logic [7:0] byte_in,
  input  wire logic       first,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] byte_out
);

  localparam int KCW    = $clog2(MAX_KEY_BYTES + 1);
  localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KPW    = (KCW > 3) ? KCW : 3;
  localparam logic [KCW-1:0] MAX_CNT = KCW'(MAX_KEY_BYTES);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_KS_RD = 7'b0000010,
    ST_KS_B  = 7'b0000100,
    ST_KS_C  = 7'b0001000,
    ST_ST_B  = 7'b0010000,
    ST_ST_C  = 7'b0100000,
    ST_ST_D  = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [KCW-1:0]     key_count;
  logic [KPW-1:0]     kpos;
  logic [7:0]         n_idx;
  logic [7:0]         jk;
  logic [7:0]         idx_i;
  logic [7:0]         idx_j;
  logic [7:0]         si;
  logic [7:0]         sj;
  logic [7:0]         t_idx;
  logic               fwd;
  logic [7:0]         data_byte;

  logic               accept;
  logic               out_free;
  logic [KCW-1:0]     key_eff;
  logic               key_we;
  logic [KEY_AW-1:0]  key_raddr;
  logic [7:0]         key_rdata;
  logic [PERM_AW-1:0] perm_raddr;
  logic [7:0]         perm_rdata;
  perm_wr_t           perm_wr;
  logic               perm_clear;
  logic [KPW:0]       kpos_inc;
  logic [KPW:0]       key_len;
  logic [KPW-1:0]     kpos_next;
  logic [7:0]         kbyte;
  logic [7:0]         jk_new;
  logic [7:0]         j_new;
  logic [7:0]         t_new;
  logic [7:0]         ks_byte;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Key store write: first restarts the count, saturate at the limit
  assign key_eff = first ? '0 : key_count;
  assign key_we  = accept && (operation == OP_KEY) && (key_eff < MAX_CNT);

  // Key position advance, wrapping at the stored or default key length
  assign kpos_inc  = {1'b0, kpos} + {{KPW{1'b0}}, 1'b1};
  assign key_len   = (key_count != '0) ? (KPW+1)'(key_count) : (KPW+1)'(DEFAULT_KEY_LEN);
  assign kpos_next = (kpos_inc >= key_len) ? '0 : kpos_inc[KPW-1:0];
  assign key_raddr = kpos[KEY_AW-1:0];

  // Schedule and stream arithmetic
  assign kbyte   = (key_count != '0) ? key_rdata : default_key_byte(kpos[2:0]);
  assign jk_new  = jk + perm_rdata + kbyte;
  assign j_new   = idx_j + perm_rdata;
  assign t_new   = si + perm_rdata;
  assign ks_byte = fwd ? sj : perm_rdata;

  // Memory addressing and next state
  always_comb begin
    state_next = state;
    perm_raddr = n_idx;
    perm_wr    = '0;
    perm_clear = 1'b0;
    case (state)
      ST_IDLE: begin
        perm_raddr = idx_i + 8'd1;
        if (accept && (operation == OP_DATA)) begin
          if (first) begin
            perm_clear = 1'b1;
            state_next = ST_KS_RD;
          end else begin
            state_next = ST_ST_B;
          end
        end
      end
      ST_KS_RD: begin
        perm_raddr = n_idx;
        state_next = ST_KS_B;
      end
      ST_KS_B: begin
        perm_raddr    = jk_new;
        perm_wr.we    = 1'b1;
        perm_wr.waddr = jk_new;
        perm_wr.wdata = perm_rdata;
        state_next    = ST_KS_C;
      end
      ST_KS_C: begin
        perm_wr.we    = 1'b1;
        perm_wr.waddr = n_idx;
        perm_wr.wdata = perm_rdata;
        if (n_idx == 8'hFF) begin
          perm_raddr = 8'd1;
          state_next = ST_ST_B;
        end else begin
          perm_raddr = n_idx + 8'd1;
          state_next = ST_KS_B;
        end
      end
      ST_ST_B: begin
        perm_raddr    = j_new;
        perm_wr.we    = 1'b1;
        perm_wr.waddr = j_new;
        perm_wr.wdata = perm_rdata;
        state_next    = ST_ST_C;
      end
      ST_ST_C: begin
        perm_raddr    = t_new;
        perm_wr.we    = 1'b1;
        perm_wr.waddr = idx_i;
        perm_wr.wdata = perm_rdata;
        state_next    = ST_ST_D;
      end
      ST_ST_D: begin
        perm_raddr = t_idx;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      key_count <= '0;
      idx_i     <= '0;
      idx_j     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (key_we) begin
        key_count <= key_eff + KCW'(1);
      end
      // Result register: load when free, drop once taken
      if ((state == ST_ST_D) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (operation == OP_DATA) && !first) begin
            idx_i <= idx_i + 8'd1;
          end
        end
        ST_KS_C: begin
          if (n_idx == 8'hFF) begin
            idx_i <= 8'd1;
            idx_j <= 8'd0;
          end
        end
        ST_ST_B: begin
          idx_j <= j_new;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        data_byte <= byte_in;
        n_idx     <= 8'd0;
        jk        <= 8'd0;
        kpos      <= '0;
      end
      ST_KS_B: begin
        jk   <= jk_new;
        kpos <= kpos_next;
      end
      ST_KS_C: begin
        n_idx <= n_idx + 8'd1;
      end
      ST_ST_B: begin
        si <= perm_rdata;
      end
      ST_ST_C: begin
        sj    <= perm_rdata;
        t_idx <= t_new;
        fwd   <= (t_new == idx_i);
      end
      ST_ST_D: begin
        if (out_free) begin
          byte_out <= data_byte ^ ks_byte;
        end
      end
      default: begin
      end
    endcase
  end

  rc4_perm_ram u_perm (
    .clk   (clk),
    .rst   (rst),
    .clear (perm_clear),
    .wr    (perm_wr),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  rc4_key_ram #(
    .DEPTH (MAX_KEY_BYTES),
    .AW    (KEY_AW)
  ) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_eff[KEY_AW-1:0]),
    .wdata (byte_in),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/rc4_checker.sv -----
// ----------------------------------------------------------------------------
// rc4_checker
// Port-level checks on the RC4 core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       operation,
  input wire logic [7:0] byte_in,
  input wire logic       first,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] byte_out
);

  // Held result beat stays valid and stable
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out))
    else $error("output beat dropped or changed while stalled");

  // A key beat never produces a result
  a_key_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !operation && !out_valid |=> !out_valid)
    else $error("result appeared after a key beat");

  // A data beat keeps the core busy while it is processed
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation |=> !in_ready)
    else $error("input accepted while a data beat is in progress");

  // Out of reset: idle, ready, no result pending
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid)
    else $error("core not idle after reset");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

`default_nettype wire
